@@ src/sba_pkg.sv @@
// sba_pkg: shared widths, codes, state encoding and transfer structs
// for the slot bitmap allocator; no dependencies
package sba_pkg;

    // fixed field widths
    localparam int ADDR_W     = 48;
    localparam int SIZE_W     = 25;
    localparam int SIZE_RND_W = SIZE_W + 1;
    localparam int CAP_W      = 8;
    localparam int USED_W     = 7;
    localparam int STAT_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = ADDR_W;

    // slot sizes are rounded up to a multiple of this many bytes (power of two)
    localparam int SLOT_ALIGN = 256;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD_ADDR = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CAP  = 2'd2;

    // back end sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FREE,
        S_FIND,
        S_PICK,
        S_MUL,
        S_ADDR,
        S_DONE
    } t_state;

    // configuration view handed to the back end
    typedef struct packed {
        logic [ADDR_W-1:0]     base;
        logic [SIZE_RND_W-1:0] rsize;
        logic [USED_W-1:0]     capc;
        logic                  cap_load;
    } t_cfg;

    // classified request from the front end
    typedef struct packed {
        logic              cmd;
        logic              below_base;
        logic [ADDR_W-1:0] offset;
    } t_req;

    // one result item
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] slot_address;
        logic [USED_W-1:0] slots_used;
    } t_result;

endpackage

@@ src/sba_fifo.sv @@
// sba_fifo: small register queue with push/full and pop/empty sides
// no package dependencies
module sba_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp, r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_cnt == CNTW'(DEPTH));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rp];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_do_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_do_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

@@ src/sba_front.sv @@
// sba_front: accepts requests, works out the offset from the pool base
// and queues the classified request; uses sba_pkg and sba_fifo
module sba_front
    import sba_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_command,
    input  logic [ADDR_W-1:0] i_free_address,
    input  logic [ADDR_W-1:0] i_base,
    output logic              o_full,
    output t_req              o_req,
    output logic              o_req_valid,
    input  logic              i_req_pop
);

    t_req w_req;
    logic w_empty;

    // classify: frees below the base are flagged here
    always_comb begin
        w_req.cmd        = i_command;
        w_req.below_base = (i_command == CMD_FREE) && (i_free_address < i_base);
        w_req.offset     = i_free_address - i_base;
    end

    sba_fifo #(
        .WIDTH ($bits(t_req)),
        .DEPTH (DEPTH)
    ) u_req_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_req),
        .o_full  (o_full),
        .i_pop   (i_req_pop),
        .o_data  (o_req),
        .o_empty (w_empty)
    );

    assign o_req_valid = !w_empty;

endmodule

@@ src/sba_back.sv @@
// sba_back: sequencer that owns the free map, picks the lowest free slot,
// runs the shift-subtract slot divider and builds results; uses sba_pkg
module sba_back
    import sba_pkg::*;
#(
    parameter int MAX_SLOTS = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  t_req    i_req,
    input  logic    i_req_valid,
    output logic    o_req_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int SW     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int STW    = (SW > 1) ? $clog2(SW) : 1;
    localparam int NG     = (MAX_SLOTS + 7) / 8;
    localparam int PW     = NG * 8;
    localparam int GIW    = (NG > 1) ? $clog2(NG) : 1;
    localparam int RW     = SIZE_RND_W + SW;
    localparam int LIM_W  = USED_W + SIZE_RND_W;
    localparam int PROD_W = SW + SIZE_RND_W;

    t_state                r_state, n_state;
    logic [MAX_SLOTS-1:0]  r_map, n_map;
    logic [USED_W-1:0]     r_free_cnt, n_free_cnt;
    logic [ADDR_W-1:0]     r_off, n_off;
    logic [LIM_W-1:0]      r_limit;
    logic [RW-1:0]         r_rem, n_rem;
    logic [SW-1:0]         r_quo, n_quo;
    logic [STW-1:0]        r_step, n_step;
    logic [GIW-1:0]        r_grp, n_grp;
    logic [7:0]            r_byte, n_byte;
    logic [SW-1:0]         r_slot, n_slot;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [ADDR_W-1:0]     r_addr, n_addr;

    logic [MAX_SLOTS-1:0]  w_cap_ones;
    logic [PW-1:0]         w_pmap;
    logic [RW-1:0]         w_div_sub;
    logic [RW:0]           w_trial;
    logic                  w_grp_found, w_bit_found;
    logic [GIW-1:0]        w_grp;
    logic [7:0]            w_byte;
    logic [2:0]            w_bit;
    logic [GIW+2:0]        w_slot_wide;

    // ones for every slot below the clamped capacity
    always_comb begin
        for (int i = 0; i < MAX_SLOTS; i++) begin
            w_cap_ones[i] = (USED_W'(i) < i_cfg.capc);
        end
    end

    // first search level: lowest group of eight holding a free slot
    assign w_pmap = PW'(r_map);
    always_comb begin
        w_grp_found = 1'b0;
        w_grp       = '0;
        w_byte      = '0;
        for (int g = 0; g < NG; g++) begin
            if (!w_grp_found && (w_pmap[g*8 +: 8] != 8'd0)) begin
                w_grp_found = 1'b1;
                w_grp       = GIW'(g);
                w_byte      = w_pmap[g*8 +: 8];
            end
        end
    end

    // second search level: lowest free slot inside the chosen group
    always_comb begin
        w_bit_found = 1'b0;
        w_bit       = '0;
        for (int b = 0; b < 8; b++) begin
            if (!w_bit_found && r_byte[b]) begin
                w_bit_found = 1'b1;
                w_bit       = 3'(b);
            end
        end
    end
    assign w_slot_wide = {r_grp, w_bit};

    // one quotient bit of offset / rounded size per cycle
    assign w_div_sub = RW'(i_cfg.rsize) << r_step;
    assign w_trial   = {1'b0, r_rem} - {1'b0, w_div_sub};

    // sequencer: next state, datapath updates and handshakes
    always_comb begin
        n_state    = r_state;
        n_map      = r_map;
        n_free_cnt = r_free_cnt;
        n_off      = r_off;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_step     = r_step;
        n_grp      = r_grp;
        n_byte     = r_byte;
        n_slot     = r_slot;
        n_prod     = r_prod;
        n_status   = r_status;
        n_addr     = r_addr;
        o_req_pop  = 1'b0;
        o_res_push = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_req_pop = 1'b1;
                    n_off     = i_req.offset;
                    n_addr    = '0;
                    if (i_req.cmd == CMD_ALLOC) begin
                        n_state = S_FIND;
                    end else if (i_req.below_base) begin
                        n_status = STAT_BAD_ADDR;
                        n_state  = S_DONE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // slot index at or past capacity iff offset >= capacity * size
                if (r_off >= ADDR_W'(r_limit)) begin
                    n_status = STAT_BAD_ADDR;
                    n_state  = S_DONE;
                end else begin
                    n_rem   = r_off[RW-1:0];
                    n_quo   = '0;
                    n_step  = STW'(SW - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!w_trial[RW]) begin
                    n_rem         = w_trial[RW-1:0];
                    n_quo[r_step] = 1'b1;
                end
                if (r_step == '0) begin
                    n_state = S_FREE;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_FREE: begin
                // a double free leaves the bit and the count as they are
                if (!r_map[r_quo]) begin
                    n_free_cnt = r_free_cnt + 1'b1;
                end
                n_map[r_quo] = 1'b1;
                n_status     = STAT_OK;
                n_state      = S_DONE;
            end
            S_FIND: begin
                if (!w_grp_found) begin
                    n_status = STAT_EMPTY;
                    n_state  = S_DONE;
                end else begin
                    n_grp   = w_grp;
                    n_byte  = w_byte;
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                n_slot                 = w_slot_wide[SW-1:0];
                n_map[w_slot_wide[SW-1:0]] = 1'b0;
                n_free_cnt             = r_free_cnt - 1'b1;
                n_state                = S_MUL;
            end
            S_MUL: begin
                n_prod  = PROD_W'(r_slot) * PROD_W'(i_cfg.rsize);
                n_state = S_ADDR;
            end
            S_ADDR: begin
                n_addr   = i_cfg.base + ADDR_W'(r_prod);
                n_status = STAT_OK;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // capacity write reloads the free map
        if (i_cfg.cap_load) begin
            n_map      = w_cap_ones;
            n_free_cnt = i_cfg.capc;
        end
    end

    // result item
    always_comb begin
        o_res.status       = r_status;
        o_res.slot_address = r_addr;
        o_res.slots_used   = i_cfg.capc - r_free_cnt;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // free map and free count, full after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map      <= '1;
            r_free_cnt <= USED_W'(MAX_SLOTS);
        end else begin
            r_map      <= n_map;
            r_free_cnt <= n_free_cnt;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_off    <= n_off;
        r_limit  <= LIM_W'(i_cfg.capc) * LIM_W'(i_cfg.rsize);
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_step   <= n_step;
        r_grp    <= n_grp;
        r_byte   <= n_byte;
        r_slot   <= n_slot;
        r_prod   <= n_prod;
        r_status <= n_status;
        r_addr   <= n_addr;
    end

endmodule

@@ src/slot_bitmap_allocator_unit.sv @@
// slot_bitmap_allocator_unit: top level with configuration registers,
// front end, back end and result queue; uses sba_pkg, sba_front, sba_back, sba_fifo
//
// Slot allocator over a pool of up to MAX_SLOTS equal slots. Push allocate or
// free requests in, pop one result per request in request order. Requests wait
// in a two-entry queue and results in another, so either side may stall freely.
// The back end handles one request at a time. It takes a request at the clock
// edge after the request is accepted, if it is idle. It then stays busy until
// it pushes the result, going through these steps:
// - a successful allocate: two-level lowest free slot search, slot times size
//   multiply, base add
// - a free inside the pool: capacity check, then the shift-subtract divider
//   that yields one slot index bit per cycle, then the free map update
// - an allocate on a full pool ends after the first search level
// - a free below the base goes straight to its result, and one past capacity
//   ends after the capacity check. A full result queue holds the back end on
// its finished result until a result is popped. Configuration is to be written
// by the user only while the block is idle; the block does not enforce this. A
// capacity write reloads the free map on the following cycle.
module slot_bitmap_allocator_unit
    import sba_pkg::*;
#(
    parameter int MAX_SLOTS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request side
    input  logic                  push,
    output logic                  full,
    input  logic                  i_command,
    input  logic [ADDR_W-1:0]     i_free_address,
    // result side
    output logic                  empty,
    input  logic                  pop,
    output logic [STAT_W-1:0]     o_status,
    output logic [ADDR_W-1:0]     o_slot_address,
    output logic [USED_W-1:0]     o_slots_used,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [ADDR_W-1:0]     r_base;
    logic [SIZE_W-1:0]     r_size;
    logic [CAP_W-1:0]      r_cap;
    logic                  r_cap_load;
    logic [SIZE_RND_W-1:0] r_rsize;
    logic [SIZE_RND_W-1:0] w_size_nz;
    logic [USED_W-1:0]     w_capc;
    t_cfg                  w_cfg;
    t_req                  w_req;
    logic                  w_req_valid, w_req_pop;
    logic                  w_res_full, w_res_push;
    t_result               w_res, w_res_out;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base     <= '0;
            r_size     <= SIZE_W'(256);
            r_cap      <= CAP_W'(64);
            r_cap_load <= 1'b0;
        end else begin
            r_cap_load <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BASE: begin
                        r_base <= i_cfg_data[ADDR_W-1:0];
                    end
                    REG_SIZE: begin
                        r_size <= i_cfg_data[SIZE_W-1:0];
                    end
                    REG_CAP: begin
                        r_cap      <= i_cfg_data[CAP_W-1:0];
                        r_cap_load <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // slot size of zero counts as one, then round up to the alignment
    assign w_size_nz = (r_size == '0) ? SIZE_RND_W'(1) : SIZE_RND_W'(r_size);
    always_ff @(posedge i_clk) begin
        r_rsize <= (w_size_nz + SIZE_RND_W'(SLOT_ALIGN - 1)) &
                   ~SIZE_RND_W'(SLOT_ALIGN - 1);
    end

    // capacity clamp
    assign w_capc = (r_cap > CAP_W'(MAX_SLOTS)) ? USED_W'(MAX_SLOTS) : r_cap[USED_W-1:0];

    always_comb begin
        w_cfg.base     = r_base;
        w_cfg.rsize    = r_rsize;
        w_cfg.capc     = w_capc;
        w_cfg.cap_load = r_cap_load;
    end

    sba_front #(
        .DEPTH (2)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_command      (i_command),
        .i_free_address (i_free_address),
        .i_base         (r_base),
        .o_full         (full),
        .o_req          (w_req),
        .o_req_valid    (w_req_valid),
        .i_req_pop      (w_req_pop)
    );

    sba_back #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req       (w_req),
        .i_req_valid (w_req_valid),
        .o_req_pop   (w_req_pop),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    // result queue
    sba_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_status       = w_res_out.status;
    assign o_slot_address = w_res_out.slot_address;
    assign o_slots_used   = w_res_out.slots_used;

`ifndef NO_ASSERTIONS
    // the back end only takes requests that are waiting
    a_pop_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_pop |-> w_req_valid)
        else $error("request taken from an empty queue");

    // a finished result is never pushed into a full result queue
    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_push |-> !w_res_full)
        else $error("result pushed into a full queue");

    // only a successful allocate carries an address
    a_addr_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != STAT_OK) |-> (o_slot_address == '0))
        else $error("failed request carries a slot address");
`endif

endmodule
